// ===== src/pes_pkg.sv =====
package pes_pkg;

    localparam int TIME_W = 32;
    localparam int TAG_W  = 16;
    localparam int SLOT_W = 4;

    // at most this many fired results are reported per tick
    localparam int RESULT_CAP = 16;
    localparam int NRES_W     = $clog2(RESULT_CAP + 1);

    localparam logic [1:0] ACT_REGISTER = 2'd0;
    localparam logic [1:0] ACT_ENABLE   = 2'd1;
    localparam logic [1:0] ACT_DISABLE  = 2'd2;
    localparam logic [1:0] ACT_TICK     = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic              enabled;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] due;
    } entry_t;

    typedef struct packed {
        logic              entry_we;   // tag, period and due
        logic              due_we;     // due only
        logic              en_we;
        logic              en_val;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] due;
    } tbl_wr_t;

endpackage

// ===== src/pes_if.sv =====
interface pes_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [pes_pkg::TAG_W-1:0]  callback_tag;
    logic [pes_pkg::TIME_W-1:0] interval;
    logic [pes_pkg::TIME_W-1:0] time_now;

    modport source (output valid, action, callback_tag, interval, time_now, input ready);
    modport sink   (input valid, action, callback_tag, interval, time_now, output ready);
endinterface

interface pes_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic                       fired;
    logic [pes_pkg::TAG_W-1:0]  fired_tag;
    logic [pes_pkg::SLOT_W-1:0] fired_slot;
    logic                       last;

    modport source (output valid, status, fired, fired_tag, fired_slot, last, input ready);
    modport sink   (input valid, status, fired, fired_tag, fired_slot, last, output ready);
endinterface

interface pes_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pes_pkg::TIME_W-1:0] time_divisor;

    modport source (output valid, time_divisor, input ready);
    modport sink   (input valid, time_divisor, output ready);
endinterface

// ===== src/pes_div.sv =====
module pes_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pes_pkg::TIME_W-1:0] dividend,
    input  logic [pes_pkg::TIME_W-1:0] divisor,
    output logic                       done,
    output logic [pes_pkg::TIME_W-1:0] quotient
);

    localparam int W   = pes_pkg::TIME_W;
    localparam int CW  = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    rem_sh;
    logic [W:0]    diff;

    // restoring divide, one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[W-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                cnt_reg  <= CW'(W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!diff[W])
                begin
                    rem_reg <= diff[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/pes_table.sv =====
module pes_table #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      rd_addr,
    output pes_pkg::entry_t       rd_data,
    input  logic [IDX_W-1:0]      wr_addr,
    input  pes_pkg::tbl_wr_t      wr
);

    logic [pes_pkg::TAG_W-1:0]  tag_mem    [DEPTH];
    logic [pes_pkg::TIME_W-1:0] period_mem [DEPTH];
    logic [pes_pkg::TIME_W-1:0] due_mem    [DEPTH];
    logic [DEPTH-1:0]           en_reg;
    logic                       rd_en_reg;
    logic [pes_pkg::TAG_W-1:0]  rd_tag_reg;
    logic [pes_pkg::TIME_W-1:0] rd_period_reg;
    logic [pes_pkg::TIME_W-1:0] rd_due_reg;

    always_ff @(posedge clk)
    begin
        if (wr.entry_we)
        begin
            tag_mem[wr_addr]    <= wr.tag;
            period_mem[wr_addr] <= wr.period;
        end
        if (wr.entry_we || wr.due_we)
        begin
            due_mem[wr_addr] <= wr.due;
        end
        rd_tag_reg    <= tag_mem[rd_addr];
        rd_period_reg <= period_mem[rd_addr];
        rd_due_reg    <= due_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= '0;
            rd_en_reg <= 1'b0;
        end
        else
        begin
            if (wr.en_we)
            begin
                en_reg[wr_addr] <= wr.en_val;
            end
            rd_en_reg <= en_reg[rd_addr];
        end
    end

    assign rd_data = {rd_en_reg, rd_tag_reg, rd_period_reg, rd_due_reg};

endmodule

// ===== src/periodic_event_scheduler.sv =====
// Periodic event scheduler: a table of up to TABLE_DEPTH periodic events.
// req carries action, callback_tag, interval and time_now; rsp returns
// status, fired, fired_tag, fired_slot and last. cfg writes time_divisor
// (0 behaves as 1) and is always ready; write it only while idle.
// One item is worked at a time; req.ready is high only between items, but a
// result still waiting on rsp does not keep the next item out.
// Busy time after the input transfer is set by the sequencer walking the
// single table read port (a read step and a check step per entry visited)
// and by the bit-serial divider:
//   register: compare, divide, table write, output load;
//     a rejected register takes compare and output load only
//   enable/disable: read and check of each entry up to the match, or
//     of every entry and a finish step when no tag matches
//   tick: every entry, a finish step, one output load per result transfer
// A tick reports each due entry, up to RESULT_CAP, as one transfer; last
// marks the final one; a tick with nothing due gives one transfer, fired low.
// Results sit in an output register; while rsp.ready is low the walk holds
// at the next result and nothing is dropped.
// Reset empties the table, clears all enable flags and sets the divisor to 1.
module periodic_event_scheduler #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    pes_req_if.sink      req,
    pes_rsp_if.source    rsp,
    pes_cfg_if.sink      cfg
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int W     = pes_pkg::TIME_W;
    localparam int TW    = pes_pkg::TAG_W;
    localparam int SW    = pes_pkg::SLOT_W;
    localparam int NW    = pes_pkg::NRES_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG_CHK,
        S_DIV,
        S_REG_WR,
        S_RD,
        S_CHK,
        S_FIN,
        S_EMIT
    } state_t;

    state_t             state_reg;
    state_t             ret_reg;
    logic [W-1:0]       divisor_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [NW-1:0]      nres_reg;

    logic [1:0]         act_reg;
    logic [TW-1:0]      tag_reg;
    logic [W-1:0]       run_reg;
    logic [W-1:0]       now_reg;

    logic               pend_valid_reg;
    logic [TW-1:0]      pend_tag_reg;
    logic [SW-1:0]      pend_slot_reg;

    logic [1:0]         res_status_reg;
    logic               res_fired_reg;
    logic [TW-1:0]      res_tag_reg;
    logic [SW-1:0]      res_slot_reg;
    logic               res_last_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic               out_fired_reg;
    logic [TW-1:0]      out_tag_reg;
    logic [SW-1:0]      out_slot_reg;
    logic               out_last_reg;

    logic [W-1:0]       div_eff;
    logic               div_start;
    logic               div_done;
    logic [W-1:0]       quotient;
    logic [W-1:0]       add_b;
    logic [W-1:0]       sum;
    logic               hit;
    logic               match;
    pes_pkg::entry_t    rd;
    pes_pkg::tbl_wr_t   wr;
    logic [IDX_W-1:0]   wr_addr;
    logic               out_free;

    assign div_eff   = (divisor_reg == '0) ? W'(1) : divisor_reg;
    assign div_start = (state_reg == S_REG_CHK) && !(run_reg < div_eff)
                       && (count_reg != CNT_W'(TABLE_DEPTH));

    // one adder serves both the new entry's due time and every reschedule
    assign add_b = (state_reg == S_REG_WR) ? quotient : rd.period;
    assign sum   = now_reg + add_b;
    assign hit   = rd.enabled && (rd.due == now_reg);
    assign match = (rd.tag == tag_reg);

    assign out_free = !out_valid_reg || rsp.ready;

    pes_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (run_reg),
        .divisor  (div_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    pes_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd),
        .wr_addr (wr_addr),
        .wr      (wr)
    );

    always_comb
    begin
        wr        = '0;
        wr.tag    = tag_reg;
        wr.period = quotient;
        wr.due    = sum;
        wr_addr   = idx_reg[IDX_W-1:0];
        if (state_reg == S_REG_WR)
        begin
            wr.entry_we = 1'b1;
            wr.en_we    = 1'b1;
            wr.en_val   = 1'b0;
            wr_addr     = count_reg[IDX_W-1:0];
        end
        else if (state_reg == S_CHK)
        begin
            if (act_reg == pes_pkg::ACT_TICK)
            begin
                wr.due_we = hit;
            end
            else if (match)
            begin
                wr.en_we  = 1'b1;
                wr.en_val = (act_reg == pes_pkg::ACT_ENABLE);
                wr.due_we = (act_reg == pes_pkg::ACT_ENABLE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            divisor_reg    <= W'(1);
            count_reg      <= '0;
            idx_reg        <= '0;
            nres_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                divisor_reg <= cfg.time_divisor;
            end
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        act_reg        <= req.action;
                        tag_reg        <= req.callback_tag;
                        run_reg        <= req.interval;
                        now_reg        <= req.time_now;
                        idx_reg        <= '0;
                        nres_reg       <= '0;
                        pend_valid_reg <= 1'b0;
                        res_fired_reg  <= 1'b0;
                        res_tag_reg    <= '0;
                        res_slot_reg   <= '0;
                        res_last_reg   <= 1'b1;
                        if (req.action == pes_pkg::ACT_REGISTER)
                        begin
                            state_reg <= S_REG_CHK;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_REG_CHK:
                begin
                    ret_reg <= S_IDLE;
                    if (run_reg < div_eff)
                    begin
                        res_status_reg <= pes_pkg::ST_SHORT;
                        state_reg      <= S_EMIT;
                    end
                    else if (count_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        res_status_reg <= pes_pkg::ST_FULL;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_REG_WR;
                    end
                end
                S_REG_WR:
                begin
                    res_status_reg <= pes_pkg::ST_OK;
                    res_slot_reg   <= SW'(count_reg);
                    count_reg      <= count_reg + 1'b1;
                    ret_reg        <= S_IDLE;
                    state_reg      <= S_EMIT;
                end
                S_RD:
                begin
                    // read address goes out now, data is checked next cycle
                    if (idx_reg == count_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_RD;
                    if (act_reg == pes_pkg::ACT_TICK)
                    begin
                        if (hit && (nres_reg != NW'(pes_pkg::RESULT_CAP)))
                        begin
                            nres_reg       <= nres_reg + 1'b1;
                            pend_valid_reg <= 1'b1;
                            pend_tag_reg   <= rd.tag;
                            pend_slot_reg  <= SW'(idx_reg);
                            if (pend_valid_reg)
                            begin
                                // earlier hit is not the final one
                                res_status_reg <= pes_pkg::ST_OK;
                                res_fired_reg  <= 1'b1;
                                res_tag_reg    <= pend_tag_reg;
                                res_slot_reg   <= pend_slot_reg;
                                res_last_reg   <= 1'b0;
                                ret_reg        <= S_RD;
                                state_reg      <= S_EMIT;
                            end
                        end
                    end
                    else if (match)
                    begin
                        res_status_reg <= pes_pkg::ST_OK;
                        ret_reg        <= S_IDLE;
                        state_reg      <= S_EMIT;
                    end
                end
                S_FIN:
                begin
                    ret_reg      <= S_IDLE;
                    state_reg    <= S_EMIT;
                    res_last_reg <= 1'b1;
                    if (act_reg == pes_pkg::ACT_TICK)
                    begin
                        res_status_reg <= pes_pkg::ST_OK;
                        res_fired_reg  <= pend_valid_reg;
                        res_tag_reg    <= pend_valid_reg ? pend_tag_reg : '0;
                        res_slot_reg   <= pend_valid_reg ? pend_slot_reg : '0;
                    end
                    else
                    begin
                        res_status_reg <= pes_pkg::ST_NOT_FOUND;
                        res_fired_reg  <= 1'b0;
                        res_tag_reg    <= '0;
                        res_slot_reg   <= '0;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_fired_reg  <= res_fired_reg;
                        out_tag_reg    <= res_tag_reg;
                        out_slot_reg   <= res_slot_reg;
                        out_last_reg   <= res_last_reg;
                        state_reg      <= ret_reg;
                    end
                end
            endcase
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.fired      = out_fired_reg;
    assign rsp.fired_tag  = out_tag_reg;
    assign rsp.fired_slot = out_slot_reg;
    assign rsp.last       = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.fired |-> rsp.status == pes_pkg::ST_OK)
        else $error("fired result with non-ok status");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("ready held after transfer");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide phase");

endmodule
